// ===== hw/rtl/ttd_pkg.sv =====
// ttd_pkg: shared types and constants for the tap tempo block
// word layouts of the channels, register codes and sequencer states
// no dependencies
`default_nettype none

package ttd_pkg;

    // field widths
    localparam int TIMER_W   = 16;
    localparam int TICK_W    = 8;
    localparam int INTEG_W   = 8;
    localparam int TA_W      = 3;
    localparam int TC_W      = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // default history depth
    localparam int MAX_TAPS_DEF = 4;

    // divider retires this many quotient bits per cycle
    localparam int DIV_BPS = 4;

    localparam logic [TIMER_W-1:0] CLAMP_MARGIN = 16'd10;
    localparam logic [TIMER_W-1:0] TIMER_MAX    = 16'hFFFF;

    // register reset values
    localparam logic [INTEG_W-1:0] DEBOUNCE_LIMIT_RST   = 8'd10;
    localparam logic [TIMER_W-1:0] TAP_TIMEOUT_RST      = 16'd1182;
    localparam logic [TIMER_W-1:0] LONG_PRESS_LIMIT_RST = 16'd1000;
    localparam logic [TA_W-1:0]    TAPS_AVERAGED_RST    = 3'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE_LIMIT   = 2'd0,
        REG_TAP_TIMEOUT      = 2'd1,
        REG_LONG_PRESS_LIMIT = 2'd2,
        REG_TAPS_AVERAGED    = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic              switch_raw;
        logic [TICK_W-1:0] tap_ticks;
        logic [TICK_W-1:0] hold_ticks;
        logic              feedback_active;
    } t_in_word;

    typedef struct packed {
        logic [TIMER_W-1:0] delay_time;
        logic               delay_updated;
        logic               long_press;
        logic               double_press_pulse;
        logic               switch_down;
    } t_out_word;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] reg_index;
        logic [CFG_DAT_W-1:0] wdata;
    } t_cfg_word;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TIMER,
        ST_DECIDE,
        ST_CLAMP,
        ST_GROW,
        ST_SLIDE_RD,
        ST_SLIDE_WR,
        ST_SLIDE_LAST,
        ST_DIV,
        ST_FINISH
    } t_state;

endpackage

`default_nettype wire

// ===== hw/rtl/ttd_if.sv =====
// valid/ready channel interfaces of the tap tempo block
// poll input, result output and register write channels
// depends on ttd_pkg
`default_nettype none

interface ttd_in_if import ttd_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ttd_out_if import ttd_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ttd_cfg_if import ttd_pkg::*; ();
    logic      valid;
    logic      ready;
    t_cfg_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tap_tempo_debounced.sv =====
// tap_tempo_debounced: tap tempo switch with integrator debounce
// top level, sequencer, interval history memory and shared sum/divide unit
// depends on ttd_pkg and the channel interfaces in ttd_if.sv
//
// usage:
//   i_in takes one word per switch poll (raw level, tap and hold ticks,
//   feedback flag); o_out returns exactly one result word per poll.
//   i_cfg writes the four registers by index; it is always ready. Write it
//   only while the block is idle; the block itself does not enforce this.
// timing:
//   a poll with no tap recorded passes timer and decide and loads its
//   result word in finish. a recorded tap while the history grows
//   passes clamp, grow and the divide steps; once the window slides it
//   passes clamp, a read and a write state per history entry moved, the
//   last write and the divide steps, one entry copied per read/write
//   pair; the divider retires 4 quotient bits per cycle. i_in.ready is
//   high only in idle, the cycle after a result word loads.
// reset:
//   synchronous, active low; config registers return to their defaults, the
//   history reads as zero (valid bits cleared), tap count goes to one.
// stall:
//   the result sits in an output register; the next poll is accepted while
//   it waits, and that poll's result holds in the sequencer until the
//   output register is taken.
`default_nettype none

module tap_tempo_debounced
    import ttd_pkg::*;
#(
    parameter int MAX_TAPS = MAX_TAPS_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    ttd_in_if.sink     i_in,
    ttd_out_if.source  o_out,
    ttd_cfg_if.sink    i_cfg
);

    // window never exceeds what the 3-bit averaging count can ask for
    localparam int TA_MAX    = (1 << TA_W) - 1;
    localparam int MAX_N     = (MAX_TAPS < TA_MAX) ? MAX_TAPS : TA_MAX;
    localparam int AW        = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int SUM_W     = TIMER_W + $clog2(MAX_N);
    localparam int DIV_STEPS = (SUM_W + DIV_BPS - 1) / DIV_BPS;
    localparam int DQ_W      = DIV_STEPS * DIV_BPS;
    localparam int DSC_W     = $clog2(DIV_STEPS);
    localparam int CW        = ((AW > TA_W) ? AW : TA_W) + 1;

    // configuration registers
    logic [INTEG_W-1:0] r_debounce_limit;
    logic [TIMER_W-1:0] r_tap_timeout;
    logic [TIMER_W-1:0] r_long_press_limit;
    logic [TA_W-1:0]    r_taps_averaged;

    // latched poll
    logic               r_sw;
    logic               r_fb;
    logic [TICK_W-1:0]  r_tticks;
    logic [TICK_W-1:0]  r_hticks;

    // tap tempo state
    t_state             r_state, n_state;
    logic [INTEG_W-1:0] r_integ;
    logic               r_pressed;
    logic [TIMER_W-1:0] r_itimer;
    logic [TC_W-1:0]    r_tap_count;
    logic [SUM_W-1:0]   r_sum;
    logic [TIMER_W-1:0] r_avg;
    logic               r_fresh;
    logic [TIMER_W-1:0] r_htimer;
    logic               r_hold_started;
    logic               r_hold_flag;
    logic               r_pulse;
    logic               r_grow;
    logic [AW-1:0]      r_idx;

    // history memory, valid bits stand in for the zero reset
    logic [TIMER_W-1:0] r_hist [MAX_TAPS];
    logic [MAX_TAPS-1:0] r_hvalid;
    logic [TIMER_W-1:0] r_rd_data;
    logic               r_rd_valid;

    // divider
    logic [TA_W-1:0]    r_div;
    logic [DQ_W-1:0]    r_quo;
    logic [TA_W-1:0]    r_rem;
    logic [DSC_W-1:0]   r_dstep;

    // output register
    logic               r_out_valid;
    t_out_word          r_out_word;

    // combinational signals
    logic [TA_W-1:0]    win_n;
    logic [TA_W-1:0]    win_n_m1;
    logic [TIMER_W:0]   it_sum;
    logic [TIMER_W:0]   ht_sum;
    logic [TIMER_W-1:0] it_sat;
    logic [TIMER_W-1:0] ht_sat;
    logic [TIMER_W-1:0] clamp_val;
    logic [TIMER_W-1:0] it_clamped;
    logic               tap_grow;
    logic               dec_new_seq;
    logic               dec_tap;
    logic               dec_release;
    logic               hf_eff;
    logic [TIMER_W-1:0] ht_eff;
    logic               hold_hit;
    logic [TIMER_W-1:0] rd_val;
    logic [TIMER_W-1:0] add_op;
    logic [SUM_W-1:0]   sum_add;
    logic               slide_more;
    logic [DQ_W-1:0]    quo_n;
    logic [TA_W-1:0]    rem_n;
    logic [TA_W:0]      trial;
    logic               in_accept;
    logic               out_load;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [TIMER_W-1:0] mem_wdata;
    logic [AW-1:0]      mem_raddr;

    assign in_accept = i_in.valid & i_in.ready;

    // window size: zero acts as one, large values clip to the depth
    always_comb begin
        if (r_taps_averaged == '0) begin
            win_n = TA_W'(1);
        end else if (int'(r_taps_averaged) > MAX_N) begin
            win_n = TA_W'(MAX_N);
        end else begin
            win_n = r_taps_averaged;
        end
        win_n_m1 = win_n - TA_W'(1);
    end

    // saturating timers
    always_comb begin
        it_sum = {1'b0, r_itimer} + {{(TIMER_W + 1 - TICK_W){1'b0}}, r_tticks};
        ht_sum = {1'b0, r_htimer} + {{(TIMER_W + 1 - TICK_W){1'b0}}, r_hticks};
        it_sat = it_sum[TIMER_W] ? TIMER_MAX : it_sum[TIMER_W-1:0];
        ht_sat = ht_sum[TIMER_W] ? TIMER_MAX : ht_sum[TIMER_W-1:0];
    end

    // branch of the poll, taken from the updated timers and integrator
    always_comb begin
        dec_new_seq = (r_integ == '0) && (r_itimer >= r_tap_timeout);
        dec_tap     = (r_integ == '0) && (r_itimer < r_tap_timeout) &&
                      !r_hold_flag && !r_pressed;
        dec_release = (r_integ != '0) && (r_integ >= r_debounce_limit);
        // a new hold restarts the hold timer before the long press check
        hf_eff      = r_hold_started ? r_hold_flag : 1'b0;
        ht_eff      = r_hold_started ? r_htimer : '0;
        hold_hit    = (ht_eff >= r_long_press_limit) && !hf_eff;
    end

    // interval clamp to timeout minus margin
    always_comb begin
        clamp_val  = (r_tap_timeout >= CLAMP_MARGIN) ? r_tap_timeout - CLAMP_MARGIN : '0;
        it_clamped = (r_itimer >= clamp_val) ? clamp_val : r_itimer;
        tap_grow   = r_tap_count <= {{(TC_W - TA_W){1'b0}}, win_n};
    end

    // shared accumulate adder
    assign rd_val  = r_rd_valid ? r_rd_data : '0;
    assign add_op  = (r_state == ST_SLIDE_WR) ? rd_val : r_itimer;
    assign sum_add = r_sum + {{(SUM_W - TIMER_W){1'b0}}, add_op};

    assign slide_more = ({{(CW - AW){1'b0}}, r_idx} + CW'(2)) <
                        {{(CW - TA_W){1'b0}}, win_n};

    // restoring divider, a few quotient bits per cycle
    always_comb begin
        rem_n = r_rem;
        quo_n = r_quo;
        trial = '0;
        for (int k = 0; k < DIV_BPS; k++) begin
            trial = {rem_n, quo_n[DQ_W-1]};
            quo_n = {quo_n[DQ_W-2:0], 1'b0};
            if (trial >= {1'b0, r_div}) begin
                trial    = trial - {1'b0, r_div};
                quo_n[0] = 1'b1;
            end
            rem_n = trial[TA_W-1:0];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_accept) n_state = ST_TIMER;
            end
            ST_TIMER: n_state = ST_DECIDE;
            ST_DECIDE: begin
                if (dec_tap) n_state = ST_CLAMP;
                else         n_state = ST_FINISH;
            end
            ST_CLAMP: begin
                if (tap_grow)             n_state = ST_GROW;
                else if (win_n > TA_W'(1)) n_state = ST_SLIDE_RD;
                else                      n_state = ST_SLIDE_LAST;
            end
            ST_GROW:     n_state = ST_DIV;
            ST_SLIDE_RD: n_state = ST_SLIDE_WR;
            ST_SLIDE_WR: begin
                if (slide_more) n_state = ST_SLIDE_RD;
                else            n_state = ST_SLIDE_LAST;
            end
            ST_SLIDE_LAST: n_state = ST_DIV;
            ST_DIV: begin
                if (r_dstep == '0) n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_load) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control outputs of the sequencer
    always_comb begin
        i_in.ready  = 1'b0;
        i_cfg.ready = 1'b1;
        out_load    = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = r_itimer;
        mem_raddr   = '0;
        case (r_state)
            ST_IDLE: i_in.ready = 1'b1;
            ST_GROW: begin
                mem_we    = 1'b1;
                mem_waddr = AW'(r_tap_count - TC_W'(1));
            end
            ST_SLIDE_RD: mem_raddr = AW'({{(CW - AW){1'b0}}, r_idx} + CW'(1));
            ST_SLIDE_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx;
                mem_wdata = rd_val;
            end
            ST_SLIDE_LAST: begin
                mem_we    = 1'b1;
                mem_waddr = AW'(win_n_m1);
            end
            ST_FINISH: out_load = !r_out_valid || o_out.ready;
            default: ;
        endcase
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_word;

    // history memory
    always_ff @(posedge i_clk) begin
        if (mem_we) r_hist[mem_waddr] <= mem_wdata;
        r_rd_data  <= r_hist[mem_raddr];
        r_rd_valid <= r_hvalid[mem_raddr];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_limit   <= DEBOUNCE_LIMIT_RST;
            r_tap_timeout      <= TAP_TIMEOUT_RST;
            r_long_press_limit <= LONG_PRESS_LIMIT_RST;
            r_taps_averaged    <= TAPS_AVERAGED_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (t_cfg_reg'(i_cfg.data.reg_index))
                REG_DEBOUNCE_LIMIT:   r_debounce_limit   <= i_cfg.data.wdata[INTEG_W-1:0];
                REG_TAP_TIMEOUT:      r_tap_timeout      <= i_cfg.data.wdata[TIMER_W-1:0];
                REG_LONG_PRESS_LIMIT: r_long_press_limit <= i_cfg.data.wdata[TIMER_W-1:0];
                REG_TAPS_AVERAGED:    r_taps_averaged    <= i_cfg.data.wdata[TA_W-1:0];
                default: ;
            endcase
        end
    end

    // poll latch and divider working registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_sw     <= i_in.data.switch_raw;
            r_fb     <= i_in.data.feedback_active;
            r_tticks <= i_in.data.tap_ticks;
            r_hticks <= i_in.data.hold_ticks;
        end
        case (r_state)
            ST_CLAMP: r_idx <= '0;
            ST_SLIDE_WR: r_idx <= r_idx + AW'(1);
            ST_GROW: begin
                r_div   <= r_tap_count[TA_W-1:0];
                r_quo   <= DQ_W'(sum_add);
                r_rem   <= '0;
                r_dstep <= DSC_W'(DIV_STEPS - 1);
            end
            ST_SLIDE_LAST: begin
                r_div   <= win_n;
                r_quo   <= DQ_W'(sum_add);
                r_rem   <= '0;
                r_dstep <= DSC_W'(DIV_STEPS - 1);
            end
            ST_DIV: begin
                r_quo   <= quo_n;
                r_rem   <= rem_n;
                r_dstep <= r_dstep - DSC_W'(1);
            end
            default: ;
        endcase
    end

    // sequencer and tap tempo state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_integ        <= '0;
            r_pressed      <= 1'b0;
            r_itimer       <= '0;
            r_tap_count    <= TC_W'(1);
            r_sum          <= '0;
            r_avg          <= '0;
            r_fresh        <= 1'b0;
            r_htimer       <= '0;
            r_hold_started <= 1'b0;
            r_hold_flag    <= 1'b0;
            r_pulse        <= 1'b0;
            r_grow         <= 1'b0;
            r_hvalid       <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            // a load refills the output register in the cycle it drains
            if (out_load) r_out_valid <= 1'b1;
            else if (o_out.ready) r_out_valid <= 1'b0;
            if (mem_we) r_hvalid[mem_waddr] <= 1'b1;
            case (r_state)
                ST_TIMER: begin
                    r_itimer <= it_sat;
                    r_htimer <= ht_sat;
                    r_pulse  <= 1'b0;
                    if (!r_sw) begin
                        if (r_integ != '0) r_integ <= r_integ - INTEG_W'(1);
                    end else if (r_integ < r_debounce_limit) begin
                        r_integ <= r_integ + INTEG_W'(1);
                    end
                end
                ST_DECIDE: begin
                    if (dec_new_seq) begin
                        // press after the timeout: start a new tap sequence
                        r_pressed      <= 1'b1;
                        r_itimer       <= '0;
                        r_tap_count    <= TC_W'(1);
                        r_sum          <= '0;
                        r_fresh        <= 1'b0;
                        r_hvalid       <= '0;
                        r_hold_started <= 1'b1;
                        if (hold_hit) begin
                            r_htimer    <= r_long_press_limit;
                            r_hold_flag <= !r_fb;
                            r_pulse     <= r_fb;
                        end else begin
                            r_htimer    <= ht_eff;
                            r_hold_flag <= hf_eff;
                        end
                    end else if (dec_tap) begin
                        r_pressed <= 1'b1;
                    end else if (dec_release) begin
                        r_pressed      <= 1'b0;
                        r_hold_flag    <= 1'b0;
                        r_htimer       <= '0;
                        r_hold_started <= 1'b0;
                        r_integ        <= r_debounce_limit;
                    end
                end
                ST_CLAMP: begin
                    r_itimer <= it_clamped;
                    r_grow   <= tap_grow;
                    if (!tap_grow) r_sum <= '0;
                end
                ST_GROW, ST_SLIDE_WR, ST_SLIDE_LAST: r_sum <= sum_add;
                ST_DIV: begin
                    if (r_dstep == '0) begin
                        r_avg    <= quo_n[TIMER_W-1:0];
                        r_fresh  <= 1'b1;
                        r_itimer <= '0;
                        if (r_grow) r_tap_count <= r_tap_count + TC_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // result word, captured when the output register is free
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_word.delay_time         <= r_avg;
            r_out_word.delay_updated      <= r_fresh;
            r_out_word.long_press         <= r_hold_flag;
            r_out_word.double_press_pulse <= r_pulse;
            r_out_word.switch_down        <= r_pressed;
        end
    end

    // checks

    // the divider never runs against a zero divisor
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV |-> r_div != '0)
        else $error("divide with zero divisor");

    // tap count stays within one past the deepest window
    a_tap_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tap_count != '0 && int'(r_tap_count) <= MAX_N + 1)
        else $error("tap count out of range");

    // a double press pulse only comes from a held, latched press
    a_pulse_pressed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.data.double_press_pulse |-> o_out.data.switch_down)
        else $error("double press pulse without a press");

    // a finished word is never dropped while the output register is full
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_FINISH && r_out_valid && !o_out.ready |=> r_state == ST_FINISH)
        else $error("result left finish while output stalled");

endmodule

`default_nettype wire
